[rtl/dual_tone_noise_sound_generator_top_assert.svh]
// Assertion macros for the sound generator top level.
`ifndef DUAL_TONE_NOISE_SOUND_GENERATOR_TOP_ASSERT_SVH
`define DUAL_TONE_NOISE_SOUND_GENERATOR_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define DTN_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error("check failed");
`define DTN_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("check failed");
`else
`define DTN_ASSERT(lbl, clk, rst, prop)
`define DTN_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

[rtl/dtn_pkg.sv]
// Shared types, constants and helper functions of the sound generator.
package dtn_pkg;

   localparam int NUM_W  = 21;
   localparam int DEN_W  = 9;
   localparam int STEP_W = 13;
   localparam int VOICES = 12;
   localparam int VIDX_W = 4;
   localparam int RF_DEPTH = 64;
   localparam int RF_AW  = 6;

   localparam logic [1:0] OP_WRITE = 2'd0;
   localparam logic [1:0] OP_READ  = 2'd1;
   localparam logic [1:0] OP_TICK  = 2'd2;

   localparam logic [4:0] REG_VOL_LAST    = 5'h05;
   localparam logic [4:0] REG_PITCH_FIRST = 5'h08;
   localparam logic [4:0] REG_PITCH_LAST  = 5'h0D;
   localparam logic [4:0] REG_OCT_FIRST   = 5'h10;
   localparam logic [4:0] REG_OCT_LAST    = 5'h12;
   localparam logic [4:0] REG_TONE_EN     = 5'h14;
   localparam logic [4:0] REG_NOISE_EN    = 5'h15;
   localparam logic [4:0] REG_NOISE_MODE  = 5'h16;
   localparam logic [4:0] REG_CHIP_EN     = 5'h1C;

   localparam logic [15:0] WRAP       = 16'd24000;
   localparam logic [15:0] RATE_FAST  = 16'd31250;
   localparam logic [15:0] RATE_MID   = 16'd15625;
   localparam logic [15:0] RATE_SLOW  = 16'd7812;
   localparam logic [NUM_W-1:0] STEP_BASE = NUM_W'(15625);
   localparam logic [10:0] LEVEL_UNIT = 11'd90;

   typedef struct packed {
      logic [1:0] operation;
      logic [1:0] port;
      logic [7:0] write_data;
   } req_type;

   typedef struct packed {
      logic [7:0]  read_data;
      logic [13:0] left_sample;
      logic [13:0] right_sample;
   } rsp_type;

   typedef struct packed {
      logic [10:0]       pitch;
      logic [STEP_W-1:0] step;
      logic [14:0]       phase;
      logic              level;
      logic [3:0]        lvol;
      logic [3:0]        rvol;
   } voice_type;

   localparam int VOICE_W = $bits(voice_type);

   function automatic logic [10:0] level_of(input logic [3:0] vol);
      return 11'(vol) * LEVEL_UNIT;
   endfunction

   function automatic logic [15:0] noise_next(input logic [15:0] s);
      logic [15:0] n;
      n = {s[14:0], 1'b0};
      if (n[14] == n[6]) n[0] = 1'b1;
      return n;
   endfunction

endpackage

[rtl/dual_tone_noise_sound_generator_top.sv]
// Top level: bus decode, voice memory sequencer, noise generators and output register.
//
//   channel | direction | carries
//   req     | in        | operation, port, write_data
//   rsp     | out       | read_data, left_sample, right_sample
//
// One item at a time. A pitch write makes one pass through the serial divider and an
// octave write two passes. A tick walks the twelve voice entries through the voice
// memory one after another.
// Reset clears valid bits of both memories at once; no clearing pass.
// A new item is taken while the previous result waits in the output register.
module dual_tone_noise_sound_generator_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  dtn_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output dtn_pkg::rsp_type  rsp_data
);
   import dtn_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE, ST_EXEC, ST_RFRD, ST_VRD, ST_VMOD, ST_VDIV, ST_TRD, ST_TUP, ST_NOISE, ST_FIN
   } state_type;

   state_type state_ff, state_in;
   logic [1:0]  op_ff, op_in, port_ff, port_in;
   logic [7:0]  data_ff, data_in;
   logic [4:0]  latch_ff [2], latch_in [2];
   logic [5:0]  tone_en_ff [2], tone_en_in [2];
   logic [5:0]  noise_en_ff [2], noise_en_in [2];
   logic        chip_en_ff [2], chip_en_in [2];
   logic [1:0]  nmode_ff [4], nmode_in [4];
   logic [15:0] nshift_ff [4], nshift_in [4];
   logic [15:0] ncount_ff [4], ncount_in [4];
   logic [STEP_W-1:0] stepcap_ff [4], stepcap_in [4];
   logic [RF_DEPTH-1:0] rf_vld_ff, rf_vld_in;
   logic [VOICES-1:0]   vc_vld_ff, vc_vld_in;
   logic [VIDX_W-1:0]   vidx_ff, vidx_in;
   logic        pair_ff, pair_in;
   voice_type   vent_ff, vent_in;
   rsp_type     res_ff, res_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_data_ff, rsp_data_in;

   logic              chip_w;
   logic [4:0]        addr_w;
   logic [VIDX_W-1:0] base_w;
   logic [RF_AW-1:0]  rf_addr;
   logic              rf_we;
   logic [7:0]        rf_rdata;
   logic              vc_we;
   voice_type         vc_wdata, vc_rdata, vcur, vnew;
   logic              is_vol, is_pitch, is_oct;
   logic              div_start, div_busy, div_done;
   logic [NUM_W-1:0]  div_num;
   logic [DEN_W-1:0]  div_den;
   logic [STEP_W-1:0] div_q;
   logic              tc;
   logic [2:0]        td;
   logic [1:0]        tgen;
   logic [15:0]       phase_sum;
   logic [16:0]       ncnt;
   logic [15:0]       nrate, nsh;

   assign chip_w   = port_ff[1];
   assign addr_w   = latch_ff[chip_w];
   assign base_w   = chip_w ? VIDX_W'(6) : VIDX_W'(0);
   assign rf_addr  = {chip_w, addr_w};
   assign is_vol   = addr_w <= REG_VOL_LAST;
   assign is_pitch = addr_w >= REG_PITCH_FIRST && addr_w <= REG_PITCH_LAST;
   assign is_oct   = addr_w >= REG_OCT_FIRST && addr_w <= REG_OCT_LAST;
   assign vcur     = vc_vld_ff[vidx_ff] ? vc_rdata : '0;
   assign tc       = vidx_ff >= VIDX_W'(6);
   assign td       = tc ? 3'(vidx_ff - VIDX_W'(6)) : vidx_ff[2:0];
   assign tgen     = {tc, td >= 3'd3};

   dtn_ram #(.WIDTH(8), .DEPTH(RF_DEPTH)) u_rf (
      .clock(clock), .we(rf_we), .waddr(rf_addr), .wdata(data_ff),
      .raddr(rf_addr), .rdata(rf_rdata)
   );

   dtn_ram #(.WIDTH(VOICE_W), .DEPTH(VOICES)) u_voice (
      .clock(clock), .we(vc_we), .waddr(vidx_ff), .wdata(vc_wdata),
      .raddr(vidx_ff), .rdata(vc_rdata)
   );

   dtn_div u_div (
      .clock(clock), .reset(reset), .start(div_start), .num(div_num), .den(div_den),
      .busy(div_busy), .done(div_done), .quo(div_q)
   );

   always_comb begin
      state_in    = state_ff;
      op_in       = op_ff;
      port_in     = port_ff;
      data_in     = data_ff;
      latch_in    = latch_ff;
      tone_en_in  = tone_en_ff;
      noise_en_in = noise_en_ff;
      chip_en_in  = chip_en_ff;
      nmode_in    = nmode_ff;
      nshift_in   = nshift_ff;
      ncount_in   = ncount_ff;
      stepcap_in  = stepcap_ff;
      rf_vld_in   = rf_vld_ff;
      vc_vld_in   = vc_vld_ff;
      vidx_in     = vidx_ff;
      pair_in     = pair_ff;
      vent_in     = vent_ff;
      res_in      = res_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in = rsp_data_ff;
      rf_we       = 1'b0;
      vc_we       = 1'b0;
      vc_wdata    = vent_ff;
      div_start   = 1'b0;
      vnew        = vcur;
      div_num     = STEP_BASE << vcur.pitch[10:8];
      div_den     = {1'b1, ~vcur.pitch[7:0]};
      phase_sum   = 16'(vcur.phase) + 16'(vcur.step);
      ncnt        = '0;
      nrate       = '0;
      nsh         = '0;

      // drop the result once the consumer takes it
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               op_in    = req_data.operation;
               port_in  = req_data.port;
               data_in  = req_data.write_data;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            res_in   = '0;
            state_in = ST_FIN;
            case (op_ff)
               OP_WRITE: begin
                  if (port_ff[0]) begin
                     latch_in[chip_w] = data_ff[4:0];
                  end else begin
                     rf_we = 1'b1;
                     rf_vld_in[rf_addr] = 1'b1;
                     if (is_vol || is_pitch) begin
                        vidx_in  = base_w + VIDX_W'(addr_w[2:0]);
                        state_in = ST_VRD;
                     end else if (is_oct) begin
                        vidx_in  = base_w + VIDX_W'({addr_w[1:0], 1'b0});
                        pair_in  = 1'b0;
                        state_in = ST_VRD;
                     end else if (addr_w == REG_TONE_EN) begin
                        tone_en_in[chip_w] = data_ff[5:0];
                     end else if (addr_w == REG_NOISE_EN) begin
                        noise_en_in[chip_w] = data_ff[5:0];
                     end else if (addr_w == REG_CHIP_EN) begin
                        chip_en_in[chip_w] = data_ff[0];
                     end else if (addr_w == REG_NOISE_MODE) begin
                        nmode_in[{chip_w, 1'b0}] = data_ff[1:0];
                        nmode_in[{chip_w, 1'b1}] = data_ff[5:4];
                     end
                  end
               end
               OP_READ: begin
                  if (port_ff[0]) res_in.read_data = {3'b000, addr_w};
                  else state_in = ST_RFRD;
               end
               OP_TICK: begin
                  vidx_in  = '0;
                  state_in = ST_TRD;
               end
               default: state_in = ST_FIN;
            endcase
         end
         ST_RFRD: begin
            res_in.read_data = rf_vld_ff[rf_addr] ? rf_rdata : 8'h00;
            state_in = ST_FIN;
         end
         ST_VRD: state_in = ST_VMOD;
         ST_VMOD: begin
            if (is_vol) begin
               vnew.lvol = data_ff[3:0];
               vnew.rvol = data_ff[7:4];
               vc_wdata  = vnew;
               vc_we     = 1'b1;
               vc_vld_in[vidx_ff] = 1'b1;
               state_in  = ST_FIN;
            end else begin
               if (is_pitch) vnew.pitch[7:0] = data_ff;
               else vnew.pitch[10:8] = pair_ff ? data_ff[6:4] : data_ff[2:0];
               vent_in   = vnew;
               div_num   = STEP_BASE << vnew.pitch[10:8];
               div_den   = {1'b1, ~vnew.pitch[7:0]};
               div_start = 1'b1;
               state_in  = ST_VDIV;
            end
         end
         ST_VDIV: begin
            if (div_done) begin
               vc_wdata      = vent_ff;
               vc_wdata.step = div_q;
               vc_we         = 1'b1;
               vc_vld_in[vidx_ff] = 1'b1;
               if (is_oct && !pair_ff) begin
                  pair_in  = 1'b1;
                  vidx_in  = vidx_ff + VIDX_W'(1);
                  state_in = ST_VRD;
               end else begin
                  state_in = ST_FIN;
               end
            end
         end
         ST_TRD: state_in = ST_TUP;
         ST_TUP: begin
            // the first voice of each noise group lends its step to mode three
            if (td == 3'd0 || td == 3'd3) stepcap_in[tgen] = vcur.step;
            if (chip_en_ff[tc] && tone_en_ff[tc][td]) begin
               if (vcur.level) begin
                  res_in.left_sample  = res_ff.left_sample + 14'(level_of(vcur.lvol));
                  res_in.right_sample = res_ff.right_sample + 14'(level_of(vcur.rvol));
               end
               if (phase_sum >= WRAP) begin
                  vnew.phase = 15'(phase_sum - WRAP);
                  vnew.level = ~vcur.level;
               end else begin
                  vnew.phase = phase_sum[14:0];
               end
               vc_wdata = vnew;
               vc_we    = 1'b1;
               vc_vld_in[vidx_ff] = 1'b1;
            end else if (chip_en_ff[tc] && noise_en_ff[tc][td] && nshift_ff[tgen][0]) begin
               res_in.left_sample  = res_ff.left_sample + 14'(level_of(vcur.lvol));
               res_in.right_sample = res_ff.right_sample + 14'(level_of(vcur.rvol));
            end
            if (vidx_ff == VIDX_W'(VOICES - 1)) begin
               state_in = ST_NOISE;
            end else begin
               vidx_in  = vidx_ff + VIDX_W'(1);
               state_in = ST_TRD;
            end
         end
         ST_NOISE: begin
            for (int g = 0; g < 4; g++) begin
               case (nmode_ff[g])
                  2'd0:    nrate = RATE_FAST;
                  2'd1:    nrate = RATE_MID;
                  2'd2:    nrate = RATE_SLOW;
                  default: nrate = 16'(stepcap_ff[g]);
               endcase
               ncnt = 17'(ncount_ff[g]) + 17'(nrate);
               nsh  = nshift_ff[g];
               // the counter can pass the wrap point twice in one tick
               if (ncnt >= 17'(WRAP)) begin
                  ncnt = ncnt - 17'(WRAP);
                  nsh  = noise_next(nsh);
               end
               if (ncnt >= 17'(WRAP)) begin
                  ncnt = ncnt - 17'(WRAP);
                  nsh  = noise_next(nsh);
               end
               if (chip_en_ff[g / 2]) begin
                  ncount_in[g] = ncnt[15:0];
                  nshift_in[g] = nsh;
               end
            end
            state_in = ST_FIN;
         end
         ST_FIN: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_data_in  = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         latch_ff     <= '{default: '0};
         tone_en_ff   <= '{default: '0};
         noise_en_ff  <= '{default: '0};
         chip_en_ff   <= '{default: '0};
         nmode_ff     <= '{default: '0};
         nshift_ff    <= '{default: '0};
         ncount_ff    <= '{default: '0};
         rf_vld_ff    <= '0;
         vc_vld_ff    <= '0;
         vidx_ff      <= '0;
         pair_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         latch_ff     <= latch_in;
         tone_en_ff   <= tone_en_in;
         noise_en_ff  <= noise_en_in;
         chip_en_ff   <= chip_en_in;
         nmode_ff     <= nmode_in;
         nshift_ff    <= nshift_in;
         ncount_ff    <= ncount_in;
         rf_vld_ff    <= rf_vld_in;
         vc_vld_ff    <= vc_vld_in;
         vidx_ff      <= vidx_in;
         pair_ff      <= pair_in;
      end
      op_ff       <= op_in;
      port_ff     <= port_in;
      data_ff     <= data_in;
      stepcap_ff  <= stepcap_in;
      vent_ff     <= vent_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_ready = state_ff == ST_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`include "dual_tone_noise_sound_generator_top_assert.svh"

   `DTN_ASSERT(a_div_idle_when_ready, clock, reset, (state_ff == ST_IDLE) |-> !div_busy)
   `DTN_ASSERT(a_div_done_in_wait, clock, reset, div_done |-> (state_ff == ST_VDIV))
   `DTN_ASSERT(a_voice_write_states, clock, reset, vc_we |-> (state_ff == ST_VMOD || state_ff == ST_VDIV || state_ff == ST_TUP))
   `DTN_ASSERT_NEXT(a_tick_starts_at_zero, clock, reset, state_ff == ST_EXEC && op_ff == OP_TICK, vidx_ff == '0 && state_ff == ST_TRD)

endmodule

[rtl/dtn_ram.sv]
// Simple dual-port RAM with registered read data.
module dtn_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule

[rtl/dtn_div.sv]
// Bit-serial restoring divider for the tone step.
module dtn_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [dtn_pkg::NUM_W-1:0]    num,
   input  logic [dtn_pkg::DEN_W-1:0]    den,
   output logic                         busy,
   output logic                         done,
   output logic [dtn_pkg::STEP_W-1:0]   quo
);
   import dtn_pkg::*;

   logic             busy_ff, busy_in, done_ff, done_in;
   logic [4:0]       cnt_ff, cnt_in;
   logic [DEN_W-1:0] rem_ff, rem_in, den_ff, den_in;
   logic [NUM_W-1:0] num_ff, num_in;
   logic [DEN_W:0]   trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      num_in  = num_ff;
      trial   = {rem_ff, num_ff[NUM_W-1]};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = 5'(NUM_W - 1);
         rem_in  = '0;
         den_in  = den;
         num_in  = num;
      end else if (busy_ff) begin
         // quotient bits shift in where dividend bits leave
         if (trial >= {1'b0, den_ff}) begin
            rem_in = DEN_W'(trial - {1'b0, den_ff});
            num_in = {num_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DEN_W-1:0];
            num_in = {num_ff[NUM_W-2:0], 1'b0};
         end
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 5'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      num_ff <= num_in;
   end

   assign busy = busy_ff;
   assign done = done_ff;
   assign quo  = num_ff[STEP_W-1:0];
endmodule
